@@ design/gopc_pkg.sv @@
// Shared types, widths and codes of the glyph outline path converter.
package gopc_pkg;

  localparam int RAW_W       = 32;              // 26.6 coordinate width
  localparam int FRAC_BITS   = 6;               // fraction bits dropped per point
  localparam int PIX_W       = RAW_W - FRAC_BITS;
  localparam int NUM_W       = PIX_W + 1;       // magnitude of 2*d+1
  localparam int PROD_W      = 2 * NUM_W;
  localparam int RECIP_SHIFT = 28;
  // ceil(2^28 / 3): exact floor(m / 3) for every m below 2^27
  localparam logic [NUM_W-1:0] RECIP_THIRD = NUM_W'(89478486);

  localparam int FUNC_W      = 3;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  // Outline event codes
  localparam logic [FUNC_W-1:0] EV_MOVE  = 3'd0;
  localparam logic [FUNC_W-1:0] EV_LINE  = 3'd1;
  localparam logic [FUNC_W-1:0] EV_CONIC = 3'd2;
  localparam logic [FUNC_W-1:0] EV_CUBIC = 3'd3;
  localparam logic [FUNC_W-1:0] EV_END   = 3'd4;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CUBIC = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_kind_t;

  // One path command waiting to go out; elevated points carry base and numerator
  typedef struct packed {
    cmd_kind_t               kind;
    logic                    elev;
    logic signed [PIX_W-1:0] base_x;
    logic signed [PIX_W-1:0] base_y;
    logic                    neg_x;
    logic                    neg_y;
    logic [NUM_W-1:0]        mag_x;
    logic [NUM_W-1:0]        mag_y;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    slot_t [MAX_RESULTS-1:0]     slot;
  } event_t;

endpackage

@@ design/gopc_in_if.sv @@
// Outline event channel: valid/ready handshake plus event payload.
interface gopc_in_if;
  import gopc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [RAW_W-1:0] ax;
  logic signed [RAW_W-1:0] ay;
  logic signed [RAW_W-1:0] bx;
  logic signed [RAW_W-1:0] by;
  logic signed [RAW_W-1:0] cx;
  logic signed [RAW_W-1:0] cy;

  modport source (output valid, func, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, func, ax, ay, bx, by, cx, cy, output ready);
endinterface

@@ design/gopc_out_if.sv @@
// Path command channel: valid/ready handshake plus command payload.
interface gopc_out_if;
  import gopc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd_kind;
  logic signed [PIX_W-1:0] px;
  logic signed [PIX_W-1:0] py;
  logic                    last_of_run;

  modport source (output valid, cmd_kind, px, py, last_of_run, input ready);
  modport sink   (input valid, cmd_kind, px, py, last_of_run, output ready);
endinterface

@@ design/gopc_prep.sv @@
// Input register, outline state and expansion of one event into command slots.
module gopc_prep (
  input  logic             clk,
  input  logic             rst_n,
  gopc_in_if.sink          in_ch,
  input  logic             ev_take,
  output logic             ev_valid,
  output gopc_pkg::event_t ev
);
  import gopc_pkg::*;

  logic                    v_r;
  logic [FUNC_W-1:0]       func_r;
  logic signed [RAW_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  logic                    started_r, started_nxt;
  logic signed [PIX_W-1:0] last_x_r, last_x_nxt;
  logic signed [PIX_W-1:0] last_y_r, last_y_nxt;

  logic signed [PIX_W-1:0] ax_pix, ay_pix, bx_pix, by_pix, cx_pix, cy_pix;
  logic                    advance;

  function automatic slot_t plain_slot(input cmd_kind_t k,
                                       input logic signed [PIX_W-1:0] x,
                                       input logic signed [PIX_W-1:0] y);
    slot_t s;
    s        = '0;
    s.kind   = k;
    s.base_x = x;
    s.base_y = y;
    return s;
  endfunction

  // Numerator 2*(ctrl-from)+1 kept as sign and magnitude; for d < 0 the
  // magnitude is 2*~d+1, so no negation is needed
  function automatic slot_t elev_slot(input logic signed [PIX_W-1:0] fx,
                                      input logic signed [PIX_W-1:0] fy,
                                      input logic signed [PIX_W-1:0] kx,
                                      input logic signed [PIX_W-1:0] ky);
    logic signed [PIX_W:0] dx;
    logic signed [PIX_W:0] dy;
    slot_t s;
    dx       = {kx[PIX_W-1], kx} - {fx[PIX_W-1], fx};
    dy       = {ky[PIX_W-1], ky} - {fy[PIX_W-1], fy};
    s        = '0;
    s.kind   = CMD_CUBIC;
    s.elev   = 1'b1;
    s.base_x = fx;
    s.base_y = fy;
    s.neg_x  = dx[PIX_W];
    s.neg_y  = dy[PIX_W];
    s.mag_x  = {dx[PIX_W-1:0] ^ {PIX_W{dx[PIX_W]}}, 1'b1};
    s.mag_y  = {dy[PIX_W-1:0] ^ {PIX_W{dy[PIX_W]}}, 1'b1};
    return s;
  endfunction

  assign advance     = v_r && ev_take;
  assign in_ch.ready = !v_r || ev_take;
  assign ev_valid    = v_r;

  // Floor to whole pixels, flip Y (wraps in 26 bits)
  assign ax_pix = ax_r[RAW_W-1:FRAC_BITS];
  assign bx_pix = bx_r[RAW_W-1:FRAC_BITS];
  assign cx_pix = cx_r[RAW_W-1:FRAC_BITS];
  assign ay_pix = PIX_W'(0) - ay_r[RAW_W-1:FRAC_BITS];
  assign by_pix = PIX_W'(0) - by_r[RAW_W-1:FRAC_BITS];
  assign cy_pix = PIX_W'(0) - cy_r[RAW_W-1:FRAC_BITS];

  always_comb begin
    ev          = '0;
    started_nxt = started_r;
    last_x_nxt  = last_x_r;
    last_y_nxt  = last_y_r;
    case (func_r)
      EV_MOVE: begin
        if (started_r) begin
          ev.slot[0] = plain_slot(CMD_CLOSE, '0, '0);
          ev.slot[1] = plain_slot(CMD_MOVE, ax_pix, ay_pix);
          ev.count   = CNT_W'(2);
        end else begin
          ev.slot[0] = plain_slot(CMD_MOVE, ax_pix, ay_pix);
          ev.count   = CNT_W'(1);
        end
        started_nxt = 1'b1;
        last_x_nxt  = ax_pix;
        last_y_nxt  = ay_pix;
      end
      EV_LINE: begin
        ev.slot[0] = plain_slot(CMD_LINE, ax_pix, ay_pix);
        ev.count   = CNT_W'(1);
        last_x_nxt = ax_pix;
        last_y_nxt = ay_pix;
      end
      EV_CONIC: begin
        ev.slot[0] = elev_slot(last_x_r, last_y_r, ax_pix, ay_pix);
        ev.slot[1] = elev_slot(bx_pix, by_pix, ax_pix, ay_pix);
        ev.slot[2] = plain_slot(CMD_CUBIC, bx_pix, by_pix);
        ev.count   = CNT_W'(3);
        last_x_nxt = bx_pix;
        last_y_nxt = by_pix;
      end
      EV_CUBIC: begin
        ev.slot[0] = plain_slot(CMD_CUBIC, ax_pix, ay_pix);
        ev.slot[1] = plain_slot(CMD_CUBIC, bx_pix, by_pix);
        ev.slot[2] = plain_slot(CMD_CUBIC, cx_pix, cy_pix);
        ev.count   = CNT_W'(3);
        last_x_nxt = cx_pix;
        last_y_nxt = cy_pix;
      end
      EV_END: begin
        if (started_r) begin
          ev.slot[0] = plain_slot(CMD_CLOSE, '0, '0);
          ev.count   = CNT_W'(1);
        end
        started_nxt = 1'b0;
        last_x_nxt  = '0;
        last_y_nxt  = '0;
      end
      default: begin
        // unused event kinds: no command, state held
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      started_r <= 1'b0;
      last_x_r  <= '0;
      last_y_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        v_r <= in_ch.valid;
      end
      if (advance) begin
        started_r <= started_nxt;
        last_x_r  <= last_x_nxt;
        last_y_r  <= last_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      ax_r   <= in_ch.ax;
      ay_r   <= in_ch.ay;
      bx_r   <= in_ch.bx;
      by_r   <= in_ch.by;
      cx_r   <= in_ch.cx;
      cy_r   <= in_ch.cy;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && func_r == EV_END |=> !started_r && last_x_r == '0 && last_y_r == '0)
    else $error("end event left outline state set");

  a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && func_r == EV_MOVE |=> started_r)
    else $error("move did not start a figure");

  a_conic_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && func_r == EV_CONIC |=> last_x_r == $past(bx_pix) && last_y_r == $past(by_pix))
    else $error("conic did not leave its target as last point");

endmodule

@@ design/gopc_elev.sv @@
// Degree elevation of one coordinate: from + trunc((2*(ctrl-from)+1) / 3).
module gopc_elev (
  input  logic signed [gopc_pkg::PIX_W-1:0] base,
  input  logic                              neg,
  input  logic [gopc_pkg::NUM_W-1:0]        mag,
  output logic signed [gopc_pkg::PIX_W-1:0] point
);
  import gopc_pkg::*;

  logic [PROD_W-1:0]     prod;
  logic [PIX_W-1:0]      quot;
  logic signed [PIX_W:0] sum;

  // Reciprocal multiply gives floor of magnitude / 3, i.e. truncation toward zero
  assign prod = PROD_W'(mag) * PROD_W'(RECIP_THIRD);
  assign quot = prod[RECIP_SHIFT +: PIX_W];
  assign sum  = neg ? ({base[PIX_W-1], base} - {1'b0, quot})
                    : ({base[PIX_W-1], base} + {1'b0, quot});
  assign point = sum[PIX_W-1:0];

endmodule

@@ design/gopc_emit.sv @@
// Command stage: hold one expanded event and issue its commands one beat a cycle when out_ch is free.
module gopc_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_valid,
  input  gopc_pkg::event_t ev,
  output logic             ev_take,
  gopc_out_if.source       out_ch
);
  import gopc_pkg::*;

  logic                    v_r;
  event_t                  ev_r;
  logic [CNT_W-1:0]        idx_r, idx_nxt;

  logic                    out_v_r;
  cmd_kind_t               kind_r;
  logic signed [PIX_W-1:0] px_r, py_r;
  logic                    last_r;

  slot_t                   cur;
  logic signed [PIX_W-1:0] elev_x, elev_y;
  logic                    out_free, emit, is_last;

  assign cur      = ev_r.slot[idx_r];
  assign out_free = !out_v_r || out_ch.ready;
  assign emit     = v_r && (ev_r.count != '0) && out_free;
  assign is_last  = (idx_r == ev_r.count - CNT_W'(1));
  assign ev_take  = !v_r || (ev_r.count == '0) || (emit && is_last);
  assign idx_nxt  = idx_r + CNT_W'(1);

  gopc_elev u_elev_x (
    .base  (cur.base_x),
    .neg   (cur.neg_x),
    .mag   (cur.mag_x),
    .point (elev_x)
  );

  gopc_elev u_elev_y (
    .base  (cur.base_y),
    .neg   (cur.neg_y),
    .mag   (cur.mag_y),
    .point (elev_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (ev_take) begin
        v_r   <= ev_valid;
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_nxt;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take && ev_valid) begin
      ev_r <= ev;
    end
    if (emit) begin
      kind_r <= cur.kind;
      px_r   <= cur.elev ? elev_x : cur.base_x;
      py_r   <= cur.elev ? elev_y : cur.base_y;
      last_r <= is_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.cmd_kind    = kind_r;
  assign out_ch.px          = px_r;
  assign out_ch.py          = py_r;
  assign out_ch.last_of_run = last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && ev_r.count != '0 |-> idx_r < ev_r.count)
    else $error("command index past event's command count");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ev_take && ev_valid |=> v_r && idx_r == '0)
    else $error("new event did not restart at its first command");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    emit && is_last && !ev_valid |=> !v_r)
    else $error("event stage still busy after its final command");

endmodule

@@ design/glyph_outline_path_converter.sv @@
// Top level of the glyph outline path converter.
//
//   channel  | dir | handshake             | beat payload
//   ---------+-----+-----------------------+----------------------------------------
//   in_ch    | in  | in_ch.valid/ready     | func, ax, ay, bx, by, cx, cy (26.6)
//   out_ch   | out | out_ch.valid/ready    | cmd_kind, px, py, last_of_run
//
// Commands: a move with no open figure or a line gives one command, and an end
//   gives a close only while a figure is open; a move that closes a figure gives
//   two, a conic or a cubic three. They leave one at a time through the single
//   command register feeding out_ch, after the input and event registers.
// Reset: rst_n synchronous, active low; clears all valids and the outline
//   state (no open figure, last point at the origin).
// Stalls: out_ch.ready low holds the command register; the event stage and
//   input register then fill, after which in_ch.ready drops.
module glyph_outline_path_converter (
  input logic        clk,
  input logic        rst_n,
  gopc_in_if.sink    in_ch,
  gopc_out_if.source out_ch
);
  import gopc_pkg::*;

  // Handoff from the expansion stage to the command stage
  logic   ev_valid;
  logic   ev_take;
  event_t ev;

  // Register the event, track the open figure and last point, and expand
  // the event into up to three command slots (closes, pixel points, and
  // elevation numerators for the conic control points)
  gopc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ev_take  (ev_take),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // Walk the slots, finish conic control points with a divide by three,
  // and advance one command beat per cycle into the output register while it is free
  gopc_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_take  (ev_take),
    .out_ch   (out_ch)
  );

endmodule
